// ===== src/bdpl_pkg.sv =====
// Shared types and constants for the button debounce and press latch unit.
package bdpl_pkg;

    localparam int FIELD_W         = 3;
    localparam int CNT_W           = 8;
    localparam int NUM_BUTTONS_DEF = 3;

    localparam logic [CNT_W-1:0] TICKS_RST = '1;

    typedef struct packed {
        logic               tick;
        logic [FIELD_W-1:0] pin_levels;
        logic [FIELD_W-1:0] consume_mask;
    } t_in_beat;

    typedef struct packed {
        logic [FIELD_W-1:0] pressed;
        logic [FIELD_W-1:0] debouncing;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic drain;
    } t_stage_ctl;

endpackage

// ===== src/button_debounce_press_latch_unit.sv =====
// Top level of the button debounce and press latch unit.
// Takes one beat per clock (tick flag, active-low pin levels, consume mask) and
// returns one result beat per input beat: the beat is captured in an input
// register, the per-button debounce update runs in one pass of shallow logic,
// and the result lands in an output register. Sustained
// rate is one beat per cycle while the output side does not stall; a stalled
// result holds in the output register and the input register keeps the next
// beat. The countdown reload value is written through i_cfg_we / i_cfg_wdata
// and resets to 255; write it only while no beat is in flight.
module button_debounce_press_latch_unit #(
    parameter int NUM_BUTTONS = bdpl_pkg::NUM_BUTTONS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bdpl_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  bdpl_pkg::t_in_beat         i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output bdpl_pkg::t_out_beat        o_out_data
);

    logic                 w_in_valid;
    bdpl_pkg::t_in_beat   w_in_beat;
    bdpl_pkg::t_out_beat  w_res;
    bdpl_pkg::t_stage_ctl w_in_ctl;
    bdpl_pkg::t_stage_ctl w_out_ctl;
    logic                 w_adv;

    // Advance the held beat when the result register is free or emptying.
    assign w_adv      = w_in_valid && (!o_out_valid || !i_out_stall);
    assign o_in_stall = w_in_valid && !w_adv;

    assign w_in_ctl.load   = i_in_valid && !o_in_stall;
    assign w_in_ctl.drain  = w_adv;
    assign w_out_ctl.load  = w_adv;
    assign w_out_ctl.drain = o_out_valid && !i_out_stall;

    bdpl_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_in_ctl),
        .i_beat  (i_in_data),
        .o_valid (w_in_valid),
        .o_beat  (w_in_beat)
    );

    bdpl_core #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_adv       (w_adv),
        .i_beat      (w_in_beat),
        .o_res       (w_res)
    );

    bdpl_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_out_ctl),
        .i_beat  (w_res),
        .o_valid (o_out_valid),
        .o_beat  (o_out_data)
    );

endmodule

// ===== src/bdpl_in_reg.sv =====
// Input register stage holding one accepted beat.
module bdpl_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bdpl_pkg::t_stage_ctl i_ctl,
    input  bdpl_pkg::t_in_beat i_beat,
    output logic               o_valid,
    output bdpl_pkg::t_in_beat o_beat
);

    logic               r_valid;
    logic               n_valid;
    bdpl_pkg::t_in_beat r_beat;

    always_comb begin
        n_valid = r_valid;
        if (i_ctl.load) begin
            n_valid = 1'b1;
        end else if (i_ctl.drain) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

// ===== src/bdpl_core.sv =====
// Per-button debounce state, countdowns and press latches, updated once per beat.
module bdpl_core #(
    parameter int NUM_BUTTONS = bdpl_pkg::NUM_BUTTONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bdpl_pkg::CNT_W-1:0]    i_cfg_wdata,
    input  logic                          i_adv,
    input  bdpl_pkg::t_in_beat            i_beat,
    output bdpl_pkg::t_out_beat           o_res
);

    localparam int PW = (NUM_BUTTONS > bdpl_pkg::FIELD_W) ? NUM_BUTTONS : bdpl_pkg::FIELD_W;

    logic [bdpl_pkg::CNT_W-1:0] r_ticks;
    logic [NUM_BUTTONS-1:0]     r_prev;
    logic [NUM_BUTTONS-1:0]     n_prev;
    logic [NUM_BUTTONS-1:0]     r_active;
    logic [NUM_BUTTONS-1:0]     n_active;
    logic [NUM_BUTTONS-1:0]     r_latch;
    logic [NUM_BUTTONS-1:0]     n_latch;
    logic [bdpl_pkg::CNT_W-1:0] r_cd [NUM_BUTTONS];
    logic [bdpl_pkg::CNT_W-1:0] n_cd [NUM_BUTTONS];
    logic [bdpl_pkg::CNT_W-1:0] w_cd_dec [NUM_BUTTONS];

    logic [PW-1:0]          w_pins_pad;
    logic [PW-1:0]          w_cons_pad;
    logic [NUM_BUTTONS-1:0] w_pins;
    logic [NUM_BUTTONS-1:0] w_cons;
    logic [NUM_BUTTONS-1:0] w_upd_latch;
    logic [NUM_BUTTONS-1:0] w_shown;

    // Buttons with no pin in the beat read as released and never consume.
    assign w_pins_pad = PW'(i_beat.pin_levels) | ~PW'({bdpl_pkg::FIELD_W{1'b1}});
    assign w_cons_pad = PW'(i_beat.consume_mask);
    assign w_pins     = w_pins_pad[NUM_BUTTONS-1:0];
    assign w_cons     = w_cons_pad[NUM_BUTTONS-1:0];

    always_comb begin
        n_active    = r_active;
        w_upd_latch = r_latch;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            // Tick comes first: decrement every running countdown.
            if (i_beat.tick && (r_cd[b] != '0)) begin
                w_cd_dec[b] = r_cd[b] - bdpl_pkg::CNT_W'(1);
            end else begin
                w_cd_dec[b] = r_cd[b];
            end
            n_cd[b] = w_cd_dec[b];
            if (r_active[b]) begin
                if (w_cd_dec[b] == '0) begin
                    w_upd_latch[b] = ~w_pins[b];
                    n_active[b]    = 1'b0;
                end
            end else if (!w_pins[b] && r_prev[b]) begin
                n_active[b] = 1'b1;
                n_cd[b]     = r_ticks;
            end
        end
        n_prev  = w_pins;
        w_shown = w_upd_latch & ~n_active;
        n_latch = w_upd_latch & ~(w_cons & ~n_active);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= bdpl_pkg::TICKS_RST;
        end else if (i_cfg_we) begin
            r_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '1;
            r_active <= '0;
            r_latch  <= '0;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_cd[b] <= '0;
            end
        end else if (i_adv) begin
            r_prev   <= n_prev;
            r_active <= n_active;
            r_latch  <= n_latch;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                r_cd[b] <= n_cd[b];
            end
        end
    end

    assign o_res.pressed    = bdpl_pkg::FIELD_W'(PW'(w_shown));
    assign o_res.debouncing = bdpl_pkg::FIELD_W'(PW'(n_active));

`ifndef SYNTHESIS
    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_active) && $stable(r_latch) && $stable(r_prev))
        else $error("debounce state changed without an advancing beat");

    a_prev_tracks_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv |=> r_prev == $past(w_pins))
        else $error("previous pin levels not taken from the last beat");

    a_no_press_while_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv |-> (o_res.pressed & o_res.debouncing) == '0)
        else $error("press reported for a debouncing button");

    a_start_loads_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && (n_active[0] && !r_active[0])) |=> r_cd[0] == r_ticks)
        else $error("debounce start did not load the countdown");
`endif

endmodule

// ===== src/bdpl_out_reg.sv =====
// Result register holding one beat until the downstream side takes it.
module bdpl_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bdpl_pkg::t_stage_ctl i_ctl,
    input  bdpl_pkg::t_out_beat i_beat,
    output logic                o_valid,
    output bdpl_pkg::t_out_beat o_beat
);

    logic                r_valid;
    logic                n_valid;
    bdpl_pkg::t_out_beat r_beat;

    always_comb begin
        n_valid = r_valid;
        if (i_ctl.load) begin
            n_valid = 1'b1;
        end else if (i_ctl.drain) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_beat <= i_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule
